[rtl/core/isotp_ss_pkg.sv]
// ----------------------------------------------------------------------------
// isotp_ss_pkg
// Types and constants shared by the ISO-TP segmented sender modules.
// ----------------------------------------------------------------------------
package isotp_ss_pkg;

    localparam int CFG_DATA_W = 29;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_PEER_ID    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SERVICE_ID = 1'b1;

    localparam logic [28:0] PEER_ID_RST    = 29'h1F00007B;
    localparam logic [7:0]  SERVICE_ID_RST = 8'h21;

    localparam logic [1:0] ACT_START = 2'd0;
    localparam logic [1:0] ACT_DATA  = 2'd1;
    localparam logic [1:0] ACT_FRAME = 2'd2;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_NEG = 2'd1;
    localparam logic [1:0] ST_LEN = 2'd2;
    localparam logic [1:0] ST_SEQ = 2'd3;

    localparam logic       KIND_FRAME  = 1'b0;
    localparam logic       KIND_STATUS = 1'b1;

    localparam logic [11:0] LEN_MIN     = 12'd5;
    localparam logic [11:0] LEN_MAX     = 12'd4094;
    localparam logic [3:0]  PCI_FIRST   = 4'h1;
    localparam logic [3:0]  PCI_FLOW    = 4'h3;
    localparam logic [3:0]  PCI_SINGLE  = 4'h0;
    localparam logic [7:0]  SEQ_START   = 8'h21;
    localparam logic [7:0]  SEQ_MASK    = 8'h2F;
    localparam logic [7:0]  RSP_BIT     = 8'h40;
    localparam logic [2:0]  FILL_FIRST  = 3'd3;
    localparam logic [2:0]  FILL_CONS   = 3'd1;
    localparam logic [2:0]  FILL_LAST   = 3'd7;

    typedef enum logic [4:0] {
        PH_IDLE  = 5'b00001,
        PH_FIRST = 5'b00010,
        PH_FC    = 5'b00100,
        PH_CONS  = 5'b01000,
        PH_RESP  = 5'b10000
    } t_phase;

    typedef struct packed {
        logic [1:0]  action;
        logic [11:0] block_length;
        logic [7:0]  data_byte;
        logic [28:0] rx_identifier;
        logic [7:0]  rx_first_byte;
        logic [7:0]  rx_second_byte;
    } t_in_word;

    typedef struct packed {
        logic        result_kind;
        logic [63:0] frame_bytes;
        logic [1:0]  status;
    } t_out_word;

    typedef struct packed {
        logic      valid;
        t_out_word word;
    } t_result;

endpackage

[rtl/core/isotp_ss_in_stage.sv]
// ----------------------------------------------------------------------------
// isotp_ss_in_stage
// Input register: holds one accepted word until the engine consumes it.
// ----------------------------------------------------------------------------
module isotp_ss_in_stage (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  isotp_ss_pkg::t_in_word i_word,
    input  logic                   i_take,
    output logic                   o_valid,
    output isotp_ss_pkg::t_in_word o_word
);
    import isotp_ss_pkg::*;

    logic     r_valid;
    t_in_word r_word;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_word <= i_word;
        end
    end

endmodule

[rtl/core/isotp_ss_engine.sv]
// ----------------------------------------------------------------------------
// isotp_ss_engine
// Segmentation state, configuration registers and the per-word update.
// ----------------------------------------------------------------------------
module isotp_ss_engine (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [isotp_ss_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [isotp_ss_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  logic                                  i_fire,
    input  isotp_ss_pkg::t_in_word                i_word,
    output isotp_ss_pkg::t_result                 o_result
);
    import isotp_ss_pkg::*;

    logic [28:0] r_peer_id;
    logic [7:0]  r_service_id;

    t_phase      r_phase,  n_phase;
    logic [11:0] r_total,  n_total;
    logic [11:0] r_taken,  n_taken;
    logic [63:0] r_buf,    n_buf;
    logic [2:0]  r_fill,   n_fill;
    logic [7:0]  r_seq,    n_seq;

    logic [11:0] len_plus;
    logic [11:0] taken_inc;
    logic [7:0]  seq_inc;
    logic [63:0] buf_upd;
    logic        cons_done;
    t_result     res;

    assign len_plus  = i_word.block_length + 12'd1;
    assign taken_inc = r_taken + 12'd1;
    assign seq_inc   = (r_seq + 8'd1) & SEQ_MASK;
    assign buf_upd   = r_buf | ({56'd0, i_word.data_byte} << {r_fill, 3'b000});
    assign cons_done = taken_inc >= r_total;

    always_comb begin
        n_phase = r_phase;
        n_total = r_total;
        n_taken = r_taken;
        n_buf   = r_buf;
        n_fill  = r_fill;
        n_seq   = r_seq;
        res     = '0;
        case (i_word.action)
            ACT_START: begin
                if (r_phase != PH_IDLE) begin
                    n_phase = PH_IDLE;
                    res.valid = 1'b1;
                    res.word.result_kind = KIND_STATUS;
                    res.word.status = ST_SEQ;
                end else if (i_word.block_length < LEN_MIN ||
                             i_word.block_length > LEN_MAX) begin
                    res.valid = 1'b1;
                    res.word.result_kind = KIND_STATUS;
                    res.word.status = ST_LEN;
                end else begin
                    n_total = i_word.block_length;
                    n_taken = '0;
                    n_seq   = SEQ_START;
                    n_buf   = {40'd0, r_service_id, len_plus[7:0], PCI_FIRST,
                               len_plus[11:8]};
                    n_fill  = FILL_FIRST;
                    n_phase = PH_FIRST;
                end
            end
            ACT_DATA: begin
                if (!(r_phase inside {PH_FIRST, PH_CONS})) begin
                    n_phase = PH_IDLE;
                    res.valid = 1'b1;
                    res.word.result_kind = KIND_STATUS;
                    res.word.status = ST_SEQ;
                end else begin
                    n_buf   = buf_upd;
                    n_taken = taken_inc;
                    n_fill  = r_fill + 3'd1;
                    if (r_phase == PH_FIRST) begin
                        if (r_fill == FILL_LAST) begin
                            n_phase = PH_FC;
                            res.valid = 1'b1;
                            res.word.result_kind = KIND_FRAME;
                            res.word.frame_bytes = buf_upd;
                        end
                    end else if (r_fill == FILL_LAST || cons_done) begin
                        n_seq = seq_inc;
                        if (cons_done) begin
                            n_phase = PH_RESP;
                        end else begin
                            n_buf  = {56'd0, seq_inc};
                            n_fill = FILL_CONS;
                        end
                        res.valid = 1'b1;
                        res.word.result_kind = KIND_FRAME;
                        res.word.frame_bytes = buf_upd;
                    end
                end
            end
            ACT_FRAME: begin
                if (i_word.rx_identifier == r_peer_id) begin
                    if (r_phase == PH_FC) begin
                        if (i_word.rx_first_byte[7:4] == PCI_FLOW) begin
                            if (r_taken >= r_total) begin
                                n_phase = PH_RESP;
                            end else begin
                                n_phase = PH_CONS;
                                n_buf   = {56'd0, r_seq};
                                n_fill  = FILL_CONS;
                            end
                        end
                    end else if (r_phase == PH_RESP) begin
                        n_phase = PH_IDLE;
                        res.valid = 1'b1;
                        res.word.result_kind = KIND_STATUS;
                        res.word.status =
                            (i_word.rx_first_byte[7:4] == PCI_SINGLE &&
                             i_word.rx_second_byte == (r_service_id | RSP_BIT))
                            ? ST_OK : ST_NEG;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign o_result.valid = i_fire && res.valid;
    assign o_result.word  = res.word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peer_id    <= PEER_ID_RST;
            r_service_id <= SERVICE_ID_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PEER_ID:    r_peer_id    <= i_cfg_wdata;
                CFG_SERVICE_ID: r_service_id <= i_cfg_wdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_total <= '0;
            r_taken <= '0;
            r_buf   <= '0;
            r_fill  <= '0;
            r_seq   <= SEQ_START;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_total <= n_total;
            r_taken <= n_taken;
            r_buf   <= n_buf;
            r_fill  <= n_fill;
            r_seq   <= n_seq;
        end
    end

`ifndef SYNTH
    a_status_ends_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && o_result.word.result_kind == KIND_STATUS
        |=> r_phase == PH_IDLE)
        else $error("status result did not return to idle");

    a_first_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_FIRST |-> r_fill >= FILL_FIRST)
        else $error("first frame fill below header");

    a_cons_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_CONS |-> r_fill != 3'd0)
        else $error("consecutive frame lost its sequence byte");

    a_taken_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_FIRST || r_phase == PH_CONS) |-> r_taken < r_total)
        else $error("byte count passed block length");

    a_cons_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && o_result.word.result_kind == KIND_FRAME && r_phase == PH_CONS
        |-> o_result.word.frame_bytes[7:4] == 4'h2)
        else $error("consecutive frame sequence byte out of range");
`endif

endmodule

[rtl/core/isotp_ss_out_stage.sv]
// ----------------------------------------------------------------------------
// isotp_ss_out_stage
// Result register: holds one result word until the sink takes it.
// ----------------------------------------------------------------------------
module isotp_ss_out_stage (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  isotp_ss_pkg::t_result   i_result,
    output logic                    o_free,
    output logic                    o_valid,
    input  logic                    i_ready,
    output isotp_ss_pkg::t_out_word o_word
);
    import isotp_ss_pkg::*;

    logic      r_valid;
    t_out_word r_word;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_result.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_result.valid) begin
            r_word <= i_result.word;
        end
    end

endmodule

[rtl/core/isotp_segmented_sender.sv]
// ----------------------------------------------------------------------------
// isotp_segmented_sender
// ISO-TP segmented transmit: first frame, flow-control wait, consecutive
// frames and response check for one data block.
// ----------------------------------------------------------------------------
// Takes one word per cycle. A word is registered on acceptance and processed
// against the segmentation state once the result register is free, and any
// result lands in the result register. The input and result registers let a
// new word enter while a result waits; throughput drops only while the sink
// holds the result register full.
// Configuration writes take effect at once and belong between blocks.
module isotp_segmented_sender (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  isotp_ss_pkg::t_in_word                i_in_word,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output isotp_ss_pkg::t_out_word               o_out_word,
    input  logic                                  i_cfg_we,
    input  logic [isotp_ss_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [isotp_ss_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);
    import isotp_ss_pkg::*;

    logic     stage_valid;
    t_in_word stage_word;
    logic     out_free;
    logic     fire;
    t_result  result;

    assign fire = stage_valid && out_free;

    isotp_ss_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_word  (i_in_word),
        .i_take  (fire),
        .o_valid (stage_valid),
        .o_word  (stage_word)
    );

    isotp_ss_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_fire      (fire),
        .i_word      (stage_word),
        .o_result    (result)
    );

    isotp_ss_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_result (result),
        .o_free   (out_free),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_word   (o_out_word)
    );

endmodule
